// ===== design/rdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rdm_pkg;

  // Fraction bits of every fixed-point quantity.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Shared multiplier: signed operand A (a stage sum needs 35 bits), unsigned
  // 17-bit operand B, exact signed product.
  localparam int unsigned MUL_A_W = 35;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W + 1;

  // Digit width of the serial divide-by-three.
  localparam int unsigned DIV_DIGIT_W = 8;

  typedef struct packed {
    logic start;     // launch one product
    logic div_mode;  // 1: magnitude prepared for the divide by 6*2^F
  } mul_req_t;

endpackage

`default_nettype wire

// ===== design/rdm_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdm_mul #(
  parameter int unsigned FRAC_BITS = rdm_pkg::FRAC_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  rdm_pkg::mul_req_t                              req_i,
  input  logic signed [rdm_pkg::MUL_A_W-1:0]             a_i,
  input  logic        [rdm_pkg::MUL_B_W-1:0]             b_i,
  output logic signed [rdm_pkg::MUL_P_W-FRAC_BITS-1:0]   res_o,
  output logic                                           neg_o,
  output logic                                           done_o
);
  import rdm_pkg::*;

  localparam int unsigned RES_W = MUL_P_W - FRAC_BITS;

  localparam logic signed [MUL_P_W-1:0] HALF_LSB = MUL_P_W'(1) <<< (FRAC_BITS - 1);
  localparam logic        [MUL_P_W-1:0] DIV_BIAS = MUL_P_W'(3) << FRAC_BITS;

  logic signed [MUL_P_W-1:0] prod_q;
  logic                      div_mode_q;
  logic                      stage1_q;
  logic signed [RES_W-1:0]   res_q;
  logic                      neg_q;
  logic                      done_q;

  logic signed [MUL_P_W-1:0] bias;
  logic signed [MUL_P_W-1:0] rnd;
  logic        [MUL_P_W-1:0] mag;
  logic        [MUL_P_W-1:0] quo6;

  // Round to nearest, ties away from zero; or fold the magnitude for /(6*2^F).
  always_comb begin
    bias = HALF_LSB - (prod_q[MUL_P_W-1] ? MUL_P_W'(1) : MUL_P_W'(0));
    rnd  = (prod_q + bias) >>> FRAC_BITS;
    mag  = prod_q[MUL_P_W-1] ? MUL_P_W'(-prod_q) : MUL_P_W'(prod_q);
    quo6 = (mag + DIV_BIAS) >> (FRAC_BITS + 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      stage1_q <= req_i.start;
      done_q   <= stage1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q     <= a_i * $signed({1'b0, b_i});
      div_mode_q <= req_i.div_mode;
    end
    if (stage1_q) begin
      res_q <= div_mode_q ? $signed(quo6[RES_W-1:0]) : rnd[RES_W-1:0];
      neg_q <= prod_q[MUL_P_W-1];
    end
  end

  assign res_o  = res_q;
  assign neg_o  = neg_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== design/rdm_div3.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdm_div3 #(
  parameter int unsigned IN_W = 35
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [IN_W-1:0]     dividend_i,
  output logic [((IN_W + rdm_pkg::DIV_DIGIT_W - 1) / rdm_pkg::DIV_DIGIT_W)
                * rdm_pkg::DIV_DIGIT_W - 1:0] quo_o,
  output logic                done_o
);
  import rdm_pkg::*;

  localparam int unsigned NDIG  = (IN_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W;
  localparam int unsigned PAD_W = NDIG * DIV_DIGIT_W;
  localparam int unsigned CNT_W = $clog2(NDIG + 1);
  localparam int unsigned VAL_W = DIV_DIGIT_W + 2;
  // floor(v * 683 / 2048) equals floor(v / 3) for every v below 3 * 2^8.
  localparam logic [VAL_W-1:0] RECIP3 = VAL_W'(683);

  logic [PAD_W-1:0] work_q;
  logic [PAD_W-1:0] quo_q;
  logic [1:0]       rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  logic [VAL_W-1:0]       val;
  logic [2*VAL_W-1:0]     prod;
  logic [DIV_DIGIT_W-1:0] qdig;
  logic [VAL_W-1:0]       rem_full;

  always_comb begin
    val      = {rem_q, work_q[PAD_W-1 -: DIV_DIGIT_W]};
    prod     = val * RECIP3;
    qdig     = prod[11 +: DIV_DIGIT_W];
    rem_full = val - {1'b0, qdig, 1'b0} - {2'b00, qdig};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(NDIG);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // One digit per cycle, most significant first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= PAD_W'(dividend_i);
      rem_q  <= 2'b00;
    end else if (cnt_q != '0) begin
      work_q <= work_q << DIV_DIGIT_W;
      quo_q  <= {quo_q[PAD_W-DIV_DIGIT_W-1:0], qdig};
      rem_q  <= rem_full[1:0];
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== design/rk4_damped_motion_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Divider digits per increment: D = ceil((51 - FRAC_BITS) / 8). A stage skips the drag
//   product when its axis is commanded or resting.
// Throughput: one item at a time; the shared multiplier and the serial divide-by-three
//   set it. Input is taken again once the result is in the output slot.
// Reset: position and velocity clear to zero, registers take their power-on defaults.
module rk4_damped_motion_step_unit #(
  parameter int unsigned FRAC_BITS = rdm_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration writes
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [30:0]  cfg_wdata_i,
  // Input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // [31:0] accel_x, [63:32] accel_y
  // Result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // [31:0] pos_x, [63:32] pos_y,
                                       // [95:64] vel_x, [127:96] vel_y
);
  import rdm_pkg::*;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [1:0] CFG_REST_THR  = 2'd1;
  localparam logic [1:0] CFG_DRAG_X    = 2'd2;
  localparam logic [1:0] CFG_DRAG_Y    = 2'd3;

  localparam logic [16:0] TIME_STEP_RST = 17'd1092;
  localparam logic [30:0] REST_THR_RST  = 31'd327680;
  localparam logic [16:0] DRAG_X_RST    = 17'd64225;
  localparam logic [16:0] DRAG_Y_RST    = 17'd52429;

  // Widths that follow from the fraction bits.
  localparam int unsigned RES_W  = MUL_P_W - FRAC_BITS;      // rounded product
  localparam int unsigned QIN_W  = MUL_P_W - 2 - FRAC_BITS;  // dividend of the /3
  localparam int unsigned NDIG   = (QIN_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W;
  localparam int unsigned QUO_W  = NDIG * DIV_DIGIT_W;
  localparam int unsigned XW_A   = (RES_W + 1 > 33) ? RES_W + 1 : 33;
  localparam int unsigned XW     = (QUO_W + 2 > XW_A) ? QUO_W + 2 : XW_A;
  localparam int unsigned ACC_W  = MUL_A_W;

  localparam logic signed [XW-1:0] SAT_MAX = XW'(32'sh7FFF_FFFF);
  localparam logic signed [XW-1:0] SAT_MIN = XW'($signed(32'h8000_0000));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN,   // start a stage: velocity product or plain velocity
    ST_VEL,     // stage velocity from the product
    ST_REST,    // rest rule and drag product
    ST_DRAG,    // drag acceleration from the product
    ST_ACC,     // weight and sum the stage
    ST_FINP,    // position increment product ready, start the divider
    ST_UPDP,    // position update
    ST_FINV,    // velocity increment product ready, start the divider
    ST_UPDV,    // velocity update, next axis
    ST_DONE     // hand the result to the output slot
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = $signed(32'h8000_0000);
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Configuration
  logic [16:0] time_step_q;
  logic [30:0] rest_threshold_q;
  logic [16:0] drag_factor_x_q;
  logic [16:0] drag_factor_y_q;

  // Architectural state
  logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;

  // Sequencer and working registers
  state_e                    state_q;
  logic                      axis_q;
  logic [1:0]                k_q;
  logic signed [31:0]        cmd_x_q, cmd_y_q;
  logic signed [31:0]        v_q;
  logic signed [31:0]        a_q;
  logic signed [ACC_W-1:0]   sx_q, sv_q;
  logic signed [MUL_A_W-1:0] op_a_q;
  logic [MUL_B_W-1:0]        op_b_q;
  mul_req_t                  mreq_q;
  logic                      div_start_q;
  logic                      neg_q;
  logic                      out_valid_q;
  logic [127:0]              out_data_q;

  // Shared units
  logic signed [RES_W-1:0] mul_res;
  logic                    mul_neg;
  logic                    mul_done;
  logic [QUO_W-1:0]        div_quo;
  logic                    div_done;

  rdm_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq_q),
    .a_i    (op_a_q),
    .b_i    (op_b_q),
    .res_o  (mul_res),
    .neg_o  (mul_neg),
    .done_o (mul_done)
  );

  rdm_div3 #(
    .IN_W (QIN_W)
  ) u_div3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (mul_res[QIN_W-1:0]),
    .quo_o      (div_quo),
    .done_o     (div_done)
  );

  // Per-axis view of the state
  logic signed [31:0]      cur_vel, cur_pos, cur_cmd;
  logic [16:0]             cur_drag;
  logic [16:0]             half_step;
  logic                    at_rest;
  logic                    dbl;
  logic signed [ACC_W-1:0] sx_d, sv_d;
  logic signed [32:0]      thr_s, v_ext;
  logic signed [XW-1:0]    quo_s, upd_pos, upd_vel;
  logic                    s_acc;

  always_comb begin
    cur_vel   = axis_q ? vel_y_q : vel_x_q;
    cur_pos   = axis_q ? pos_y_q : pos_x_q;
    cur_cmd   = axis_q ? cmd_y_q : cmd_x_q;
    cur_drag  = axis_q ? drag_factor_y_q : drag_factor_x_q;
    half_step = time_step_q >> 1;

    // Strictly inside the band around zero.
    thr_s   = $signed({2'b00, rest_threshold_q});
    v_ext   = 33'(v_q);
    at_rest = (v_ext < thr_s) && (v_ext > -thr_s);

    // Weights 1, 2, 2, 1.
    dbl  = (k_q == 2'd1) || (k_q == 2'd2);
    sx_d = sx_q + (dbl ? (ACC_W'(v_q) <<< 1) : ACC_W'(v_q));
    sv_d = sv_q + (dbl ? (ACC_W'(a_q) <<< 1) : ACC_W'(a_q));

    quo_s   = $signed(XW'(div_quo));
    upd_pos = XW'(cur_pos) + (neg_q ? -quo_s : quo_s);
    upd_vel = XW'(cur_vel) + (neg_q ? -quo_s : quo_s);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q      <= TIME_STEP_RST;
      rest_threshold_q <= REST_THR_RST;
      drag_factor_x_q  <= DRAG_X_RST;
      drag_factor_y_q  <= DRAG_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TIME_STEP: time_step_q      <= cfg_wdata_i[16:0];
        CFG_REST_THR:  rest_threshold_q <= cfg_wdata_i;
        CFG_DRAG_X:    drag_factor_x_q  <= cfg_wdata_i[16:0];
        CFG_DRAG_Y:    drag_factor_y_q  <= cfg_wdata_i[16:0];
        default:       ;
      endcase
    end
  end

  // Sequencer: four stages per axis, then the two increments, x before y.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      k_q         <= 2'd0;
      mreq_q      <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
    end else begin
      mreq_q      <= '0;
      div_start_q <= 1'b0;
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            cmd_x_q <= $signed(s_axis_tdata[31:0]);
            cmd_y_q <= $signed(s_axis_tdata[63:32]);
            axis_q  <= 1'b0;
            k_q     <= 2'd0;
            sx_q    <= '0;
            sv_q    <= '0;
            a_q     <= '0;
            state_q <= ST_BEGIN;
          end
        end

        ST_BEGIN: begin
          if (k_q == 2'd0) begin
            // First stage sees the stored velocity unchanged.
            v_q     <= cur_vel;
            state_q <= ST_REST;
          end else begin
            op_a_q          <= MUL_A_W'(a_q);
            op_b_q          <= (k_q == 2'd3) ? time_step_q : half_step;
            mreq_q.start    <= 1'b1;
            mreq_q.div_mode <= 1'b0;
            state_q         <= ST_VEL;
          end
        end

        ST_VEL: begin
          if (mul_done) begin
            v_q     <= sat32(XW'(cur_vel) + XW'(mul_res));
            state_q <= ST_REST;
          end
        end

        ST_REST: begin
          if (cur_cmd == '0) begin
            if (at_rest) begin
              v_q     <= '0;
              a_q     <= '0;
              state_q <= ST_ACC;
            end else begin
              op_a_q          <= MUL_A_W'(v_q);
              op_b_q          <= cur_drag;
              mreq_q.start    <= 1'b1;
              mreq_q.div_mode <= 1'b0;
              state_q         <= ST_DRAG;
            end
          end else begin
            a_q     <= cur_cmd;
            state_q <= ST_ACC;
          end
        end

        ST_DRAG: begin
          if (mul_done) begin
            a_q     <= sat32(-XW'(mul_res));
            state_q <= ST_ACC;
          end
        end

        ST_ACC: begin
          sx_q <= sx_d;
          sv_q <= sv_d;
          if (k_q == 2'd3) begin
            // Position increment: S * dt / (6 * 2^F).
            op_a_q          <= sx_d;
            op_b_q          <= time_step_q;
            mreq_q.start    <= 1'b1;
            mreq_q.div_mode <= 1'b1;
            state_q         <= ST_FINP;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_BEGIN;
          end
        end

        ST_FINP: begin
          if (mul_done) begin
            neg_q       <= mul_neg;
            div_start_q <= 1'b1;
            state_q     <= ST_UPDP;
          end
        end

        ST_UPDP: begin
          if (div_done) begin
            if (axis_q) begin
              pos_y_q <= sat32(upd_pos);
            end else begin
              pos_x_q <= sat32(upd_pos);
            end
            op_a_q          <= sv_q;
            op_b_q          <= time_step_q;
            mreq_q.start    <= 1'b1;
            mreq_q.div_mode <= 1'b1;
            state_q         <= ST_FINV;
          end
        end

        ST_FINV: begin
          if (mul_done) begin
            neg_q       <= mul_neg;
            div_start_q <= 1'b1;
            state_q     <= ST_UPDV;
          end
        end

        ST_UPDV: begin
          if (div_done) begin
            if (axis_q) begin
              vel_y_q <= sat32(upd_vel);
              state_q <= ST_DONE;
            end else begin
              vel_x_q <= sat32(upd_vel);
              axis_q  <= 1'b1;
              k_q     <= 2'd0;
              sx_q    <= '0;
              sv_q    <= '0;
              a_q     <= '0;
              state_q <= ST_BEGIN;
            end
          end
        end

        ST_DONE: begin
          // Hold until the output slot is free.
          if (!out_valid_q || m_axis_tready) begin
            out_data_q  <= {vel_y_q, vel_x_q, pos_y_q, pos_x_q};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A product only completes while a stage or increment waits for it.
  a_mul_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mul_done)
    else $error("multiplier result arrived while idle");

  // The divider finishes only during an update step.
  a_div_done_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_UPDP || state_q == ST_UPDV))
    else $error("divider result arrived outside an update step");

  // Leaving the final state always fills the output slot and frees the input.
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && (!m_axis_tvalid || m_axis_tready))
      |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("result not loaded into the output slot");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Damped 2D motion integrator bench. Each tick item carries a commanded
// acceleration pair; the bench keeps its own fixed-point copy of the
// position/velocity state and of the four registers, runs one RK4 step per
// accepted tick and checks every result item, field by field, in order.
module testbench;

  localparam int unsigned FRAC          = rdm_pkg::FRAC_BITS_DEF;
  localparam longint unsigned ONE_Q     = 64'd1 << FRAC;
  localparam int unsigned STALL_LIMIT   = 4000;   // quiet cycles before giving up
  localparam int unsigned SETTLE_CYCLES = 120;    // a bit beyond the worst item latency
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned CHUNK_ITEMS   = 60;     // ticks between register changes

  typedef enum logic [1:0] {
    REG_TIME_STEP      = 2'd0,
    REG_REST_THRESHOLD = 2'd1,
    REG_DRAG_X         = 2'd2,
    REG_DRAG_Y         = 2'd3
  } cfg_reg_e;

  // Same layout as the result bus: pos_x in the lowest bits.
  typedef struct packed {
    logic [31:0] vel_y;
    logic [31:0] vel_x;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } motion_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [1:0]   cfg_addr_i    = REG_TIME_STEP;
  logic [30:0]  cfg_wdata_i   = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata  = '0;   // [31:0] accel_x, [63:32] accel_y
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;         // [31:0] pos_x, [63:32] pos_y,
                                      // [95:64] vel_x, [127:96] vel_y

  rk4_damped_motion_step_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the block: registers (power-on values) and motion state.
  longint unsigned step_q   = 1092;
  longint unsigned rest_q   = 327680;
  longint unsigned drag_x_q = 64225;
  longint unsigned drag_y_q = 52429;
  longint pos_x_q = 0, pos_y_q = 0, vel_x_q = 0, vel_y_q = 0;

  motion_t     expected_motion[$];
  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned snk_stall_pct  = 0;
  int unsigned quiet_cycles   = 0;
  motion_t     want_motion, got_motion;

  // ---------------------------------------------------------------------------
  // Fixed-point motion predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Divide, rounding to nearest with ties away from zero.
  function automatic longint round_div(input longint n, input longint unsigned d);
    longint unsigned mag, q;
    mag = (n < 0) ? -n : n;
    q   = (mag + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  // One RK stage of one axis: position and velocity derivatives.
  function automatic void rk_stage(input longint vel, input longint cmd,
                                   input longint dv_prev, input longint unsigned h,
                                   input longint unsigned drag,
                                   output longint dx, output longint dv);
    longint v, a, thr;
    v   = clamp32(vel + round_div(dv_prev * longint'(h), ONE_Q));
    a   = cmd;
    thr = longint'(rest_q);
    if (cmd == 0) begin
      // Free axis: a slow stage velocity counts as stopped, else drag acts.
      if (v < thr && v > -thr) begin
        v = 0;
      end else begin
        a = clamp32(-round_div(v * longint'(drag), ONE_Q));
      end
    end
    dx = v;
    dv = a;
  endfunction

  function automatic void step_axis(inout longint pos, inout longint vel,
                                    input longint cmd, input longint unsigned drag);
    longint unsigned half;
    longint ax, av, bx, bv, cx, cv, dx, dv, sum_x, sum_v;
    half = step_q >> 1;
    rk_stage(vel, cmd, 0,  0,      drag, ax, av);
    rk_stage(vel, cmd, av, half,   drag, bx, bv);
    rk_stage(vel, cmd, bv, half,   drag, cx, cv);
    rk_stage(vel, cmd, cv, step_q, drag, dx, dv);
    sum_x = ax + 2 * bx + 2 * cx + dx;
    sum_v = av + 2 * bv + 2 * cv + dv;
    pos = clamp32(pos + round_div(sum_x * longint'(step_q), 6 * ONE_Q));
    vel = clamp32(vel + round_div(sum_v * longint'(step_q), 6 * ONE_Q));
  endfunction

  function automatic void predict_tick(input logic [31:0] ax, input logic [31:0] ay);
    motion_t m;
    step_axis(pos_x_q, vel_x_q, longint'($signed(ax)), drag_x_q);
    step_axis(pos_y_q, vel_y_q, longint'($signed(ay)), drag_y_q);
    m.pos_x = pos_x_q[31:0];
    m.pos_y = pos_y_q[31:0];
    m.vel_x = vel_x_q[31:0];
    m.vel_y = vel_y_q[31:0];
    expected_motion.push_back(m);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Drive one register; the caller drops the write enable after the last one.
  task automatic write_reg(input cfg_reg_e idx, input logic [30:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_TIME_STEP:      step_q   = longint'(value[16:0]);
      REG_REST_THRESHOLD: rest_q   = longint'(value[30:0]);
      REG_DRAG_X:         drag_x_q = longint'(value[16:0]);
      REG_DRAG_Y:         drag_y_q = longint'(value[16:0]);
      default: ;
    endcase
  endtask

  // Write all four registers; only call while the block is idle.
  task automatic configure(input logic [30:0] dt, input logic [30:0] thr,
                           input logic [30:0] dfx, input logic [30:0] dfy);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_REST_THRESHOLD, thr);
    write_reg(REG_DRAG_X, dfx);
    write_reg(REG_DRAG_Y, dfy);
    cfg_we_i <= 1'b0;
  endtask

  // Send one tick; valid stays high into the next call unless that one idles.
  task automatic send_tick(input logic [31:0] ax, input logic [31:0] ay);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ay, ax};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tick(ax, ay);
  endtask

  // Hold off the sender until every expected result has come, then let the
  // block settle so register writes land on an idle datapath.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_motion.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, in-order check, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("[%0t] %s mismatch: expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_motion = m_axis_tdata;
      if (expected_motion.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("[%0t] result with nothing expected: %h", $realtime, m_axis_tdata);
        end
      end else begin
        want_motion = expected_motion.pop_front();
        if (got_motion.pos_x !== want_motion.pos_x)
          note_mismatch("pos_x", want_motion.pos_x, got_motion.pos_x);
        if (got_motion.pos_y !== want_motion.pos_y)
          note_mismatch("pos_y", want_motion.pos_y, got_motion.pos_y);
        if (got_motion.vel_x !== want_motion.vel_x)
          note_mismatch("vel_x", want_motion.vel_x, got_motion.vel_x);
        if (got_motion.vel_y !== want_motion.vel_y)
          note_mismatch("vel_y", want_motion.vel_y, got_motion.vel_y);
      end
    end
  end

  // Any handshake or register write counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Power-on registers: resting axes stay put, a hard push then coasting
  // exercises the drag path, unit accelerations probe the rounding.
  task automatic test_rest_and_drag();
    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'h0000_0001, 32'hFFFF_FFFF);
    send_tick(32'h0000_0000, 32'h0001_0000);
    wait_idle();
  endtask

  // Zero step: the state must come back unchanged whatever is commanded.
  task automatic test_zero_step();
    configure(31'd0, 31'd327680, 31'd64225, 31'd52429);
    send_tick(32'h0005_0000, 32'hFFFB_0000);
    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();
  endtask

  // All-ones writes get masked: step and horizontal drag near 2.0, no vertical
  // drag, no rest band. Full-scale pushes drive both axes into saturation.
  task automatic test_saturation();
    configure(31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 31'd0);
    repeat (3) send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    repeat (3) send_tick(32'h0000_0000, 32'h0000_0000);
    wait_idle();
  endtask

  // Widest rest band: free axes stop unless the velocity sits at the most
  // negative or most positive value, which falls outside the open band and gets drag.
  task automatic test_threshold_extremes();
    configure(31'd1092, 31'h7FFF_FFFF, 31'd65536, 31'd65536);
    send_tick(32'h0000_0000, 32'h0000_0000);
    send_tick(32'h8000_0000, 32'h0000_0000);
    send_tick(32'h0000_0000, 32'h8000_0000);
    send_tick(32'h0000_0000, 32'h0000_0000);
    wait_idle();
  endtask

  // Commands come as held maneuvers and coasting stretches, with some noise.
  function automatic logic [31:0] pick_accel(input logic [31:0] prev);
    int unsigned roll;
    int          mild;
    roll = $urandom_range(99);
    mild = int'($urandom_range(8388607)) - 4194304;   // about +/-64 in Q16.16
    if (roll < 30) return prev;
    if (roll < 60) return 32'h0000_0000;
    if (roll < 85) return mild;
    if (roll < 95) return $urandom;
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic random_config();
    logic [30:0] dt, thr, dfx, dfy;
    dt  = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(4096));
    case ($urandom_range(3))
      0:       thr = 31'd0;
      1:       thr = 31'($urandom);
      default: thr = 31'($urandom_range(1 << 20));
    endcase
    dfx = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(65536));
    dfy = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(65536));
    configure(dt, thr, dfx, dfy);
  endtask

  task automatic test_random_motion(input int unsigned tx_idle, input int unsigned rx_stall,
                                    input int unsigned n_items);
    logic [31:0] ax, ay;
    int unsigned sent;
    ax            = '0;
    ay            = '0;
    src_idle_pct  = tx_idle;
    snk_stall_pct = rx_stall;
    for (sent = 0; sent < n_items; sent++) begin
      if (sent % CHUNK_ITEMS == 0) begin
        wait_idle();
        random_config();
      end
      ax = pick_accel(ax);
      ay = pick_accel(ay);
      send_tick(ax, ay);
    end
    wait_idle();
  endtask

  initial begin
    src_idle_pct  = 33;
    snk_stall_pct = 60;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_rest_and_drag();
    test_zero_step();
    test_saturation();
    test_threshold_extremes();
    test_random_motion(33, 60, 300);
    test_random_motion(60, 33, 300);
    test_random_motion(0, 0, 300);

    if (mismatch_count == 0 && expected_motion.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
